@@ design/gvns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvns_pkg
// Shared widths, codes and types of the grid vertex normal smoother.
// ----------------------------------------------------------------------------
package gvns_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 18;
    localparam int ACC_W   = 34;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic [1:0] STAT_READ    = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_ONE_ROW = 2'd2;
    localparam logic [1:0] STAT_ZERO    = 2'd3;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_SEAM  = 2'd2;
    localparam logic [1:0] CFG_LIMIT = 2'd3;

    localparam logic [5:0]  RST_ROWS  = 6'd2;
    localparam logic [5:0]  RST_COLS  = 6'd2;
    localparam logic [5:0]  RST_SEAM  = 6'd0;
    localparam logic [15:0] RST_LIMIT = 16'd66;

    typedef logic signed [63:0] t_s64;
    typedef logic signed [31:0] t_s32;

    typedef struct packed {
        logic start;
        logic frac_hi;
    } t_unit_req;

endpackage

@@ design/gvns_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvns_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gvns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/gvns_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvns_unit
// Vector normalizer: scales a 3-vector so its largest magnitude tops out at
// bit 30, takes the integer square root of the sum of squares and divides
// each component by it, one bit per cycle.
// ----------------------------------------------------------------------------
module gvns_unit import gvns_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    input  t_s64      i_vec [3],
    output logic      o_done,
    output t_s32      o_res [3]
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_NORM = 3'd1;
    localparam logic [2:0] U_SQ   = 3'd2;
    localparam logic [2:0] U_SQRT = 3'd3;
    localparam logic [2:0] U_DSET = 3'd4;
    localparam logic [2:0] U_DIV  = 3'd5;

    logic [2:0]  r_state;
    logic        r_done;
    logic [63:0] r_a [3];
    logic [2:0]  r_neg;
    logic        r_frac_hi;
    logic [4:0]  r_cnt;
    logic [1:0]  r_k;
    logic [63:0] r_prod;
    logic [63:0] r_sum;
    logic [63:0] r_root;
    logic [34:0] r_rem;
    logic [30:0] r_num;
    logic [30:0] r_q;
    t_s32        r_res [3];

    logic [63:0] w_or;
    logic [30:0] w_ak;
    logic [63:0] w_bit;
    logic [63:0] w_try;
    logic [61:0] n_num;
    logic [34:0] w_rem2;
    logic        w_ge;
    logic [30:0] n_q;
    t_s32        w_mag;

    always_comb begin
        w_or = r_a[0] | r_a[1] | r_a[2];
        unique case (r_k)
            2'd0:    w_ak = r_a[0][30:0];
            2'd1:    w_ak = r_a[1][30:0];
            default: w_ak = r_a[2][30:0];
        endcase
        w_bit = 64'd1 << {r_cnt, 1'b0};
        w_try = r_root + w_bit;
        if (r_frac_hi) begin
            n_num = 62'({w_ak, 30'd0}) + 62'(r_root >> 1);
        end else begin
            n_num = 62'({w_ak, 16'd0}) + 62'(r_root >> 1);
        end
        w_rem2 = {r_rem[33:0], r_num[r_cnt]};
        w_ge   = w_rem2 >= 35'(r_root);
        n_q    = {r_q[29:0], w_ge};
        w_mag  = {1'b0, n_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_frac_hi <= i_req.frac_hi;
                        for (int k = 0; k < 3; k++) begin
                            r_neg[k] <= i_vec[k] < 0;
                            r_a[k]   <= (i_vec[k] < 0) ? 64'(-i_vec[k]) : 64'(i_vec[k]);
                        end
                        if (i_vec[0] == 0 && i_vec[1] == 0 && i_vec[2] == 0) begin
                            for (int k = 0; k < 3; k++) begin
                                r_res[k] <= '0;
                            end
                            r_done <= 1'b1;
                        end else begin
                            r_state <= U_NORM;
                        end
                    end
                end
                U_NORM: begin
                    // walk the common scale until the top bit lands on bit 30
                    if (w_or[63:31] != '0) begin
                        for (int k = 0; k < 3; k++) begin
                            r_a[k] <= r_a[k] >> 1;
                        end
                    end else if (w_or[63:30] == '0) begin
                        for (int k = 0; k < 3; k++) begin
                            r_a[k] <= r_a[k] << 1;
                        end
                    end else begin
                        r_k     <= 2'd0;
                        r_sum   <= '0;
                        r_state <= U_SQ;
                    end
                end
                U_SQ: begin
                    r_prod <= 64'(w_ak * w_ak);
                    if (r_k != 2'd0) begin
                        r_sum <= r_sum + r_prod;
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_cnt   <= 5'd31;
                        r_root  <= '0;
                        r_state <= U_SQRT;
                    end
                end
                U_SQRT: begin
                    if (r_sum >= w_try) begin
                        r_sum  <= r_sum - w_try;
                        r_root <= (r_root >> 1) + w_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_k     <= 2'd0;
                        r_state <= U_DSET;
                    end
                end
                U_DSET: begin
                    r_rem   <= 35'(n_num[61:31]);
                    r_num   <= n_num[30:0];
                    r_q     <= '0;
                    r_cnt   <= 5'd30;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    r_rem <= w_ge ? (w_rem2 - 35'(r_root)) : w_rem2;
                    r_q   <= n_q;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_res[r_k] <= r_neg[r_k] ? -w_mag : w_mag;
                        r_k        <= r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= U_IDLE;
                        end else begin
                            r_state <= U_DSET;
                        end
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ design/grid_vertex_normal_smoother.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vertex_normal_smoother
// Averaged vertex normals over a quad grid, with optional border seams.
// ----------------------------------------------------------------------------
// A vertex write is taken on its handshake; a normal read passes through the
// memory read register and then the result register. After reset the normal
// memory is swept to zero, one entry a cycle, with the input held off. A
// compute item holds the block until it is done: an accumulator clearing sweep
// over all MAX_ROWS*MAX_COLS entries, then per quad a fetch, edge check, cross
// product and scatter plus three passes of the shared normalizer, then one
// normalizer pass per grid vertex and per seam group. The normalizer sets the
// pace: scaling, squares, square root and a division per component, one vector
// at a time.
// ----------------------------------------------------------------------------
module grid_vertex_normal_smoother import gvns_pkg::*; #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [4:0]         i_row,
    input  logic [4:0]         i_col,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [17:0] o_nx,
    output logic signed [17:0] o_ny,
    output logic signed [17:0] o_nz,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int XB    = (RB > CB) ? RB : CB;
    localparam int VW    = 3 * COORD_W;
    localparam int NW    = 3 * NORM_W;
    localparam int AC    = 3 * ACC_W;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_ACLR  = 5'd3;
    localparam logic [4:0] S_QRD   = 5'd4;
    localparam logic [4:0] S_EDGE  = 5'd5;
    localparam logic [4:0] S_SHORT = 5'd6;
    localparam logic [4:0] S_UA    = 5'd7;
    localparam logic [4:0] S_UAW   = 5'd8;
    localparam logic [4:0] S_UB    = 5'd9;
    localparam logic [4:0] S_UBW   = 5'd10;
    localparam logic [4:0] S_CROSS = 5'd11;
    localparam logic [4:0] S_UN    = 5'd12;
    localparam logic [4:0] S_UNW   = 5'd13;
    localparam logic [4:0] S_ACC   = 5'd14;
    localparam logic [4:0] S_NRD   = 5'd15;
    localparam logic [4:0] S_NGO   = 5'd16;
    localparam logic [4:0] S_NW    = 5'd17;
    localparam logic [4:0] S_KSEL  = 5'd18;
    localparam logic [4:0] S_KRD   = 5'd19;
    localparam logic [4:0] S_KAC   = 5'd20;
    localparam logic [4:0] S_KGO   = 5'd21;
    localparam logic [4:0] S_KW    = 5'd22;
    localparam logic [4:0] S_KWR   = 5'd23;

    function automatic logic [AW-1:0] f_addr(input logic [RB-1:0] row,
                                             input logic [CB-1:0] col);
        return AW'(32'(row) * MAX_COLS + 32'(col));
    endfunction

    // registers
    logic [4:0]  r_state;
    logic [5:0]  r_rows, r_cols, r_seam;
    logic [15:0] r_limit;
    logic [31:0] r_lim_sq;
    logic [AW-1:0] r_addr;
    logic [2:0]  r_cnt;
    logic [RB-1:0] r_i, r_rm1;
    logic [CB-1:0] r_j, r_cm1;
    logic [2:0]  r_bit;
    logic [XB-1:0] r_outer, r_n;
    logic [VW-1:0] r_v [4];
    logic signed [32:0] r_ea [3];
    logic signed [32:0] r_eb [3];
    logic [35:0] r_sa, r_sb;
    logic signed [65:0] r_mprod;
    t_s32        r_ua [3];
    t_s32        r_ub [3];
    t_s32        r_nq [3];
    t_s64        r_c [3];
    t_s64        r_ks [3];
    t_s32        r_kres [3];
    logic        r_ovalid;
    logic signed [17:0] r_nx, r_ny, r_nz;
    logic [1:0]  r_status;

    // combinational
    logic          w_accept;
    logic          w_inside;
    logic [AW-1:0] w_in_addr;
    logic [RB-1:0] w_rm1;
    logic [CB-1:0] w_cm1;
    logic          w_sweep_last;
    logic [1:0]    w_corner;
    logic [RB-1:0] w_crow;
    logic [CB-1:0] w_ccol;
    logic [AW-1:0] w_caddr;
    logic [AW-1:0] w_cell;
    logic [RB-1:0] w_krow;
    logic [CB-1:0] w_kcol;
    logic [AW-1:0] w_kaddr;
    logic [XB-1:0] w_klast, w_olast;
    logic [7:0]    w_seam8;
    logic signed [32:0] w_ma, w_mb;
    logic          w_small_a, w_small_b, w_short;
    logic          w_out_load;

    logic          w_vwe;
    logic [AW-1:0] w_vwaddr, w_vraddr;
    logic [VW-1:0] w_vwdata, w_vrd;
    logic          w_nwe;
    logic [AW-1:0] w_nwaddr, w_nraddr;
    logic [NW-1:0] w_nwdata, w_nrd;
    logic          w_awe;
    logic [AW-1:0] w_awaddr, w_araddr;
    logic [AC-1:0] w_awdata, w_ard;

    t_unit_req     w_ureq;
    t_s64          w_uvec [3];
    logic          w_udone;
    t_s32          w_ures [3];

    assign w_accept     = i_valid && o_ready;
    assign w_inside     = (32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS);
    assign w_in_addr    = f_addr(RB'(i_row), CB'(i_col));
    assign w_sweep_last = r_addr == AW'(DEPTH - 1);
    assign w_cell       = f_addr(r_i, r_j);
    assign w_seam8      = {2'b00, r_seam};
    assign w_out_load   = 1'b0;

    always_comb begin
        if (r_rows == 6'd0) begin
            w_rm1 = '0;
        end else if (32'(r_rows) > MAX_ROWS) begin
            w_rm1 = RB'(MAX_ROWS - 1);
        end else begin
            w_rm1 = RB'(r_rows - 6'd1);
        end
        if (r_cols < 6'd2) begin
            w_cm1 = CB'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            w_cm1 = CB'(MAX_COLS - 1);
        end else begin
            w_cm1 = CB'(r_cols - 6'd1);
        end
    end

    // quad corners: 0 (i,j-1), 1 (i,j), 2 (i-1,j), 3 (i-1,j-1)
    always_comb begin
        w_corner = (r_state == S_ACC) ? r_cnt[2:1] : r_cnt[1:0];
        w_crow   = (w_corner[1]) ? r_i - RB'(1) : r_i;
        w_ccol   = (w_corner == 2'd0 || w_corner == 2'd3) ? r_j - CB'(1) : r_j;
        w_caddr  = f_addr(w_crow, w_ccol);
    end

    // seam group cells
    always_comb begin
        w_krow  = '0;
        w_kcol  = '0;
        w_klast = '0;
        w_olast = '0;
        unique case (r_bit)
            3'd0: begin
                w_krow  = (r_n == '0) ? '0 : r_rm1;
                w_kcol  = CB'(r_outer);
                w_klast = XB'(1);
                w_olast = XB'(r_cm1);
            end
            3'd1: begin
                w_krow  = RB'(r_outer);
                w_kcol  = (r_n == '0) ? '0 : r_cm1;
                w_klast = XB'(1);
                w_olast = XB'(r_rm1);
            end
            3'd2: begin
                w_kcol  = CB'(r_n);
                w_klast = XB'(r_cm1);
            end
            3'd3: begin
                w_krow  = r_rm1;
                w_kcol  = CB'(r_n);
                w_klast = XB'(r_cm1);
            end
            3'd4: begin
                w_krow  = RB'(r_n);
                w_klast = XB'(r_rm1);
            end
            3'd5: begin
                w_krow  = RB'(r_n);
                w_kcol  = r_cm1;
                w_klast = XB'(r_rm1);
            end
            default: begin
                w_klast = '0;
            end
        endcase
        w_kaddr = f_addr(w_krow, w_kcol);
    end

    // edge degeneracy
    always_comb begin
        w_small_a = 1'b1;
        w_small_b = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_ea[k] > 33'sd65535 || r_ea[k] < -33'sd65535) begin
                w_small_a = 1'b0;
            end
            if (r_eb[k] > 33'sd65535 || r_eb[k] < -33'sd65535) begin
                w_small_b = 1'b0;
            end
        end
        w_short = (w_small_a && r_sa < 36'(r_lim_sq)) || (w_small_b && r_sb < 36'(r_lim_sq));
    end

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_SHORT) begin
            unique case (r_cnt)
                3'd0:    w_ma = r_ea[0];
                3'd1:    w_ma = r_ea[1];
                3'd2:    w_ma = r_ea[2];
                3'd3:    w_ma = r_eb[0];
                3'd4:    w_ma = r_eb[1];
                3'd5:    w_ma = r_eb[2];
                default: w_ma = '0;
            endcase
            w_mb = w_ma;
        end else if (r_state == S_CROSS) begin
            unique case (r_cnt)
                3'd0:    begin w_ma = 33'(r_ua[1]); w_mb = 33'(r_ub[2]); end
                3'd1:    begin w_ma = 33'(r_ua[2]); w_mb = 33'(r_ub[1]); end
                3'd2:    begin w_ma = 33'(r_ua[2]); w_mb = 33'(r_ub[0]); end
                3'd3:    begin w_ma = 33'(r_ua[0]); w_mb = 33'(r_ub[2]); end
                3'd4:    begin w_ma = 33'(r_ua[0]); w_mb = 33'(r_ub[1]); end
                3'd5:    begin w_ma = 33'(r_ua[1]); w_mb = 33'(r_ub[0]); end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end
    end

    // memory ports and normalizer request
    always_comb begin
        w_vwe    = 1'b0;
        w_vwaddr = w_in_addr;
        w_vwdata = {i_z, i_y, i_x};
        w_vraddr = w_caddr;
        w_nwe    = 1'b0;
        w_nwaddr = r_addr;
        w_nwdata = '0;
        w_nraddr = w_in_addr;
        w_awe    = 1'b0;
        w_awaddr = r_addr;
        w_awdata = '0;
        w_araddr = w_caddr;
        w_ureq   = '0;
        for (int k = 0; k < 3; k++) begin
            w_uvec[k] = r_c[k];
        end
        unique case (r_state)
            S_CLR: begin
                w_nwe = 1'b1;
            end
            S_IDLE: begin
                w_vwe = w_accept && i_mode == MODE_WRITE && w_inside;
            end
            S_ACLR: begin
                w_awe = 1'b1;
            end
            S_UA: begin
                w_ureq.start   = 1'b1;
                w_ureq.frac_hi = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    w_uvec[k] = 64'(r_ea[k]);
                end
            end
            S_UB: begin
                w_ureq.start   = 1'b1;
                w_ureq.frac_hi = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    w_uvec[k] = 64'(r_eb[k]);
                end
            end
            S_UN: begin
                w_ureq.start   = 1'b1;
                w_ureq.frac_hi = 1'b1;
            end
            S_ACC: begin
                w_awe    = r_cnt[0];
                w_awaddr = w_caddr;
                for (int k = 0; k < 3; k++) begin
                    w_awdata[k*ACC_W +: ACC_W] =
                        $signed(w_ard[k*ACC_W +: ACC_W]) + ACC_W'(r_nq[k]);
                end
            end
            S_NRD: begin
                w_araddr = w_cell;
            end
            S_NGO: begin
                w_ureq.start = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    w_uvec[k] = 64'($signed(w_ard[k*ACC_W +: ACC_W]));
                end
            end
            S_NW: begin
                w_nwe    = w_udone;
                w_nwaddr = w_cell;
                w_nwdata = {w_ures[2][NORM_W-1:0], w_ures[1][NORM_W-1:0],
                            w_ures[0][NORM_W-1:0]};
            end
            S_KRD: begin
                w_nraddr = w_kaddr;
            end
            S_KGO: begin
                w_ureq.start = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    w_uvec[k] = r_ks[k];
                end
            end
            S_KWR: begin
                w_nwe    = 1'b1;
                w_nwaddr = w_kaddr;
                w_nwdata = {r_kres[2][NORM_W-1:0], r_kres[1][NORM_W-1:0],
                            r_kres[0][NORM_W-1:0]};
            end
            default: begin
                w_vwe = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            r_rows   <= RST_ROWS;
            r_cols   <= RST_COLS;
            r_seam   <= RST_SEAM;
            r_limit  <= RST_LIMIT;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROWS:  r_rows  <= i_cfg_data[5:0];
                    CFG_COLS:  r_cols  <= i_cfg_data[5:0];
                    CFG_SEAM:  r_seam  <= i_cfg_data[5:0];
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    default:   r_limit <= r_limit;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= w_out_load;
            end
            r_mprod <= w_ma * w_mb;

            unique case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + AW'(1);
                    if (w_sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_mode == MODE_READ) begin
                            if (w_inside) begin
                                r_state <= S_RD;
                            end else begin
                                r_ovalid <= 1'b1;
                                r_nx     <= '0;
                                r_ny     <= '0;
                                r_nz     <= '0;
                                r_status <= STAT_ZERO;
                            end
                        end else if (i_mode == MODE_COMPUTE) begin
                            if (w_rm1 == '0) begin
                                r_ovalid <= 1'b1;
                                r_nx     <= '0;
                                r_ny     <= '0;
                                r_nz     <= '0;
                                r_status <= STAT_ONE_ROW;
                            end else begin
                                r_rm1    <= w_rm1;
                                r_cm1    <= w_cm1;
                                r_lim_sq <= r_limit * r_limit;
                                r_addr   <= '0;
                                r_state  <= S_ACLR;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_ovalid <= 1'b1;
                    r_nx     <= w_nrd[17:0];
                    r_ny     <= w_nrd[35:18];
                    r_nz     <= w_nrd[53:36];
                    r_status <= (w_nrd == '0) ? STAT_ZERO : STAT_READ;
                    r_state  <= S_IDLE;
                end
                S_ACLR: begin
                    r_addr <= r_addr + AW'(1);
                    if (w_sweep_last) begin
                        r_i     <= RB'(1);
                        r_j     <= CB'(1);
                        r_cnt   <= '0;
                        r_state <= S_QRD;
                    end
                end
                S_QRD: begin
                    if (r_cnt != 3'd0) begin
                        r_v[2'(r_cnt - 3'd1)] <= w_vrd;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ea[k] <= 33'($signed(r_v[1][k*32 +: 32]))
                                 - 33'($signed(r_v[0][k*32 +: 32]));
                        r_eb[k] <= 33'($signed(r_v[3][k*32 +: 32]))
                                 - 33'($signed(r_v[0][k*32 +: 32]));
                    end
                    r_sa    <= '0;
                    r_sb    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SHORT;
                end
                S_SHORT: begin
                    if (r_cnt >= 3'd1 && r_cnt <= 3'd3) begin
                        r_sa <= r_sa + r_mprod[35:0];
                    end else if (r_cnt >= 3'd4 && r_cnt <= 3'd6) begin
                        r_sb <= r_sb + r_mprod[35:0];
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        // swap to the opposite corner when either edge is short
                        if (w_short) begin
                            for (int k = 0; k < 3; k++) begin
                                r_ea[k] <= 33'($signed(r_v[3][k*32 +: 32]))
                                         - 33'($signed(r_v[2][k*32 +: 32]));
                                r_eb[k] <= 33'($signed(r_v[1][k*32 +: 32]))
                                         - 33'($signed(r_v[2][k*32 +: 32]));
                            end
                        end
                        r_state <= S_UA;
                    end
                end
                S_UA: begin
                    r_state <= S_UAW;
                end
                S_UAW: begin
                    if (w_udone) begin
                        r_ua    <= w_ures;
                        r_state <= S_UB;
                    end
                end
                S_UB: begin
                    r_state <= S_UBW;
                end
                S_UBW: begin
                    if (w_udone) begin
                        r_ub    <= w_ures;
                        r_cnt   <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_c[k] <= '0;
                        end
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    if (r_cnt != 3'd0) begin
                        if (r_cnt[0]) begin
                            r_c[2'((r_cnt - 3'd1) >> 1)] <=
                                r_c[2'((r_cnt - 3'd1) >> 1)] + 64'(r_mprod);
                        end else begin
                            r_c[2'((r_cnt - 3'd1) >> 1)] <=
                                r_c[2'((r_cnt - 3'd1) >> 1)] - 64'(r_mprod);
                        end
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        r_state <= S_UN;
                    end
                end
                S_UN: begin
                    r_state <= S_UNW;
                end
                S_UNW: begin
                    if (w_udone) begin
                        r_nq    <= w_ures;
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_cnt   <= '0;
                        r_state <= S_QRD;
                        if (r_j == r_cm1) begin
                            r_j <= CB'(1);
                            if (r_i == r_rm1) begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_state <= S_NRD;
                            end else begin
                                r_i <= r_i + RB'(1);
                            end
                        end else begin
                            r_j <= r_j + CB'(1);
                        end
                    end
                end
                S_NRD: begin
                    r_state <= S_NGO;
                end
                S_NGO: begin
                    r_state <= S_NW;
                end
                S_NW: begin
                    if (w_udone) begin
                        r_state <= S_NRD;
                        if (r_j == r_cm1) begin
                            r_j <= '0;
                            if (r_i == r_rm1) begin
                                r_bit   <= '0;
                                r_state <= S_KSEL;
                            end else begin
                                r_i <= r_i + RB'(1);
                            end
                        end else begin
                            r_j <= r_j + CB'(1);
                        end
                    end
                end
                S_KSEL: begin
                    r_outer <= '0;
                    r_n     <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_ks[k] <= '0;
                    end
                    if (r_bit == 3'd6) begin
                        r_ovalid <= 1'b1;
                        r_nx     <= '0;
                        r_ny     <= '0;
                        r_nz     <= '0;
                        r_status <= STAT_DONE;
                        r_state  <= S_IDLE;
                    end else if (w_seam8[r_bit]) begin
                        r_state <= S_KRD;
                    end else begin
                        r_bit <= r_bit + 3'd1;
                    end
                end
                S_KRD: begin
                    r_state <= S_KAC;
                end
                S_KAC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ks[k] <= r_ks[k] + 64'($signed(w_nrd[k*NORM_W +: NORM_W]));
                    end
                    if (r_n == w_klast) begin
                        r_n     <= '0;
                        r_state <= S_KGO;
                    end else begin
                        r_n     <= r_n + XB'(1);
                        r_state <= S_KRD;
                    end
                end
                S_KGO: begin
                    r_state <= S_KW;
                end
                S_KW: begin
                    if (w_udone) begin
                        r_kres  <= w_ures;
                        r_state <= S_KWR;
                    end
                end
                S_KWR: begin
                    if (r_n == w_klast) begin
                        r_n <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_ks[k] <= '0;
                        end
                        if (r_outer == w_olast) begin
                            r_bit   <= r_bit + 3'd1;
                            r_state <= S_KSEL;
                        end else begin
                            r_outer <= r_outer + XB'(1);
                            r_state <= S_KRD;
                        end
                    end else begin
                        r_n <= r_n + XB'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    gvns_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vwaddr),
        .i_wdata (w_vwdata),
        .i_raddr (w_vraddr),
        .o_rdata (w_vrd)
    );

    gvns_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_nram (
        .i_clk   (i_clk),
        .i_we    (w_nwe),
        .i_waddr (w_nwaddr),
        .i_wdata (w_nwdata),
        .i_raddr (w_nraddr),
        .o_rdata (w_nrd)
    );

    gvns_ram #(.WIDTH(AC), .DEPTH(DEPTH)) u_aram (
        .i_clk   (i_clk),
        .i_we    (w_awe),
        .i_waddr (w_awaddr),
        .i_wdata (w_awdata),
        .i_raddr (w_araddr),
        .o_rdata (w_ard)
    );

    gvns_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ureq),
        .i_vec   (w_uvec),
        .o_done  (w_udone),
        .o_res   (w_ures)
    );

    assign o_ready     = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid     = r_ovalid;
    assign o_nx        = r_nx;
    assign o_ny        = r_ny;
    assign o_nz        = r_nz;
    assign o_status    = r_status;
    assign o_cfg_ready = 1'b1;

endmodule

@@ verif/grid_vertex_normal_smoother_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vertex_normal_smoother_tb
// Self-checking bench for the quad grid normal smoother. A directed table
// covers empty reads, ignored items, extreme coordinates, degenerate quads
// and zero-length normals. Random phases then reprogram the grid size, seams
// and edge limit, load meshes, compute and read back. Each read and compute
// result is checked against its table value or a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module grid_vertex_normal_smoother_tb;
    import gvns_pkg::*;

    localparam int         NROWS      = 32;
    localparam int         NCOLS      = 32;
    localparam int         NCELLS     = NROWS * NCOLS;
    localparam logic [1:0] MODE_NOP   = 2'd3;
    localparam int         RAND_ITEMS = 1500;
    localparam int         WDOG_LIMIT = 300000;
    localparam int         PRESS_LEN  = 400;

    typedef longint vec3_t [3];

    typedef struct packed {
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic [1:0]         status;
    } nrm_res_t;

    typedef struct {
        logic [1:0]         mode;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 chk;
        nrm_res_t           res;
    } stim_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_mode;
    logic [4:0]         i_row;
    logic [4:0]         i_col;
    logic signed [31:0] i_x;
    logic signed [31:0] i_y;
    logic signed [31:0] i_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [17:0] o_nx;
    logic signed [17:0] o_ny;
    logic signed [17:0] o_nz;
    logic [1:0]         o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    grid_vertex_normal_smoother #(
        .MAX_ROWS(NROWS),
        .MAX_COLS(NCOLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_x        (i_x),
        .i_y        (i_y),
        .i_z        (i_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_nx       (o_nx),
        .o_ny       (o_ny),
        .o_nz       (o_nz),
        .o_status   (o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // predictor state
    logic [5:0]  mdl_rows;
    logic [5:0]  mdl_cols;
    logic [5:0]  mdl_seam;
    logic [15:0] mdl_limit;
    int          mdl_vtx [NCELLS][3];
    int          mdl_nrm [NCELLS][3];
    longint      mdl_acc [NCELLS][3];

    nrm_res_t pending_normals [$];
    stim_t    cur_item;
    int       mismatches;
    int       fail_cnt;
    bit       no_gaps;
    bit       hold_req;
    int       idle_cycles;

    function automatic longint unsigned isqrt_u64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // scale to a 30-bit top, then divide by the truncated magnitude, rounded
    function automatic void unit_vec(input vec3_t v, input int unsigned frac,
                                     output vec3_t o);
        longint unsigned a [3];
        longint unsigned m, sum, mag, q;
        bit              neg [3];
        int unsigned     p;
        m   = 0;
        sum = 0;
        p   = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = v[k] < 0;
            a[k]   = neg[k] ? 64'(-v[k]) : 64'(v[k]);
            if (a[k] > m) m = a[k];
        end
        if (m == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while ((m >> p) > 1) p++;
        for (int k = 0; k < 3; k++) begin
            a[k] = (p < 30) ? (a[k] << (30 - p)) : (a[k] >> (p - 30));
            sum += a[k] * a[k];
        end
        mag = isqrt_u64(sum);
        for (int k = 0; k < 3; k++) begin
            q    = ((a[k] << frac) + (mag >> 1)) / mag;
            o[k] = neg[k] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic bit edge_is_short(input vec3_t d);
        longint unsigned a, sum, lim;
        sum = 0;
        lim = mdl_limit;
        for (int k = 0; k < 3; k++) begin
            a = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            if (a >= 65536) return 1'b0;
            sum += a * a;
        end
        return sum < lim * lim;
    endfunction

    function automatic void edge_vec(input int dst, input int src, output vec3_t d);
        for (int k = 0; k < 3; k++)
            d[k] = longint'(mdl_vtx[dst][k]) - longint'(mdl_vtx[src][k]);
    endfunction

    function automatic void quad_normal(input vec3_t e1, input vec3_t e2,
                                        output vec3_t n);
        vec3_t a, b, c;
        unit_vec(e1, 30, a);
        unit_vec(e2, 30, b);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        unit_vec(c, 30, n);
    endfunction

    function automatic void collapse_group(input int r0, input int c0, input int dr,
                                           input int dc, input int count);
        vec3_t s, u;
        int    idx;
        s = '{0, 0, 0};
        for (int n = 0; n < count; n++) begin
            idx = ((r0 + n * dr) * NCOLS + (c0 + n * dc)) % NCELLS;
            for (int k = 0; k < 3; k++) s[k] += mdl_nrm[idx][k];
        end
        unit_vec(s, 16, u);
        for (int n = 0; n < count; n++) begin
            idx = ((r0 + n * dr) * NCOLS + (c0 + n * dc)) % NCELLS;
            for (int k = 0; k < 3; k++) mdl_nrm[idx][k] = int'(u[k]);
        end
    endfunction

    function automatic void smooth_grid(input int nr, input int nc);
        int    q0, q1, q2, q3;
        vec3_t ea, eb, n, u;
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
                for (int k = 0; k < 3; k++) mdl_acc[i * NCOLS + j][k] = 0;
        for (int i = 1; i < nr; i++) begin
            for (int j = 1; j < nc; j++) begin
                q0 = i * NCOLS + j - 1;
                q1 = i * NCOLS + j;
                q2 = (i - 1) * NCOLS + j;
                q3 = (i - 1) * NCOLS + j - 1;
                edge_vec(q1, q0, ea);
                edge_vec(q3, q0, eb);
                // fall back to the opposite corner on a short edge
                if (edge_is_short(ea) || edge_is_short(eb)) begin
                    edge_vec(q3, q2, ea);
                    edge_vec(q1, q2, eb);
                end
                quad_normal(ea, eb, n);
                for (int k = 0; k < 3; k++) begin
                    mdl_acc[q0][k] += n[k];
                    mdl_acc[q1][k] += n[k];
                    mdl_acc[q2][k] += n[k];
                    mdl_acc[q3][k] += n[k];
                end
            end
        end
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                unit_vec('{mdl_acc[i * NCOLS + j][0], mdl_acc[i * NCOLS + j][1],
                           mdl_acc[i * NCOLS + j][2]}, 16, u);
                for (int k = 0; k < 3; k++) mdl_nrm[i * NCOLS + j][k] = int'(u[k]);
            end
        end
        if (mdl_seam[0]) for (int j = 0; j < nc; j++) collapse_group(0, j, nr - 1, 0, 2);
        if (mdl_seam[1]) for (int i = 0; i < nr; i++) collapse_group(i, 0, 0, nc - 1, 2);
        if (mdl_seam[2]) collapse_group(0, 0, 0, 1, nc);
        if (mdl_seam[3]) collapse_group(nr - 1, 0, 0, 1, nc);
        if (mdl_seam[4]) collapse_group(0, 0, 1, 0, nr);
        if (mdl_seam[5]) collapse_group(0, nc - 1, 1, 0, nr);
    endfunction

    function automatic int sat_rows(input logic [5:0] v);
        return (v < 1) ? 1 : (v > NROWS) ? NROWS : int'(v);
    endfunction

    function automatic int sat_cols(input logic [5:0] v);
        return (v < 2) ? 2 : (v > NCOLS) ? NCOLS : int'(v);
    endfunction

    function automatic bit predict_normal_item(input stim_t s, output nrm_res_t res);
        int idx;
        idx = int'(s.row) * NCOLS + int'(s.col);
        res = '0;
        case (s.mode)
            MODE_WRITE: begin
                mdl_vtx[idx][0] = s.x;
                mdl_vtx[idx][1] = s.y;
                mdl_vtx[idx][2] = s.z;
                return 1'b0;
            end
            MODE_COMPUTE: begin
                if (sat_rows(mdl_rows) == 1) begin
                    res.status = STAT_ONE_ROW;
                end else begin
                    smooth_grid(sat_rows(mdl_rows), sat_cols(mdl_cols));
                    res.status = STAT_DONE;
                end
                return 1'b1;
            end
            MODE_READ: begin
                res.nx = 18'(mdl_nrm[idx][0]);
                res.ny = 18'(mdl_nrm[idx][1]);
                res.nz = 18'(mdl_nrm[idx][2]);
                res.status = (mdl_nrm[idx][0] == 0 && mdl_nrm[idx][1] == 0 &&
                              mdl_nrm[idx][2] == 0) ? STAT_ZERO : STAT_READ;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // output check first: a result leaving now belongs to an earlier item
    always @(posedge i_clk) begin
        nrm_res_t got, want, pred;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_nx, o_ny, o_nz, o_status};
                if (pending_normals.size() == 0) begin
                    fail_cnt++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result nx=%0d ny=%0d nz=%0d st=%0d",
                                 o_nx, o_ny, o_nz, o_status);
                end else begin
                    want = pending_normals.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp nx=%0d ny=%0d nz=%0d st=%0d, got nx=%0d ny=%0d nz=%0d st=%0d",
                                     want.nx, want.ny, want.nz, want.status,
                                     o_nx, o_ny, o_nz, o_status);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS:  mdl_rows  = i_cfg_data[5:0];
                    CFG_COLS:  mdl_cols  = i_cfg_data[5:0];
                    CFG_SEAM:  mdl_seam  = i_cfg_data[5:0];
                    CFG_LIMIT: mdl_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                if (predict_normal_item(cur_item, pred))
                    pending_normals.push_back(cur_item.chk ? cur_item.res : pred);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = PRESS_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 7) == 0) hold_left = pick_gap();
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still up
    task automatic send_item(input stim_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_item = s;
        i_mode   <= s.mode;
        i_row    <= s.row;
        i_col    <= s.col;
        i_x      <= s.x;
        i_y      <= s.y;
        i_z      <= s.z;
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_normals.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic program_grid(input logic [5:0] rows, input logic [5:0] cols,
                                input logic [5:0] seam, input logic [15:0] lim);
        logic [15:0] vals [4];
        vals = '{{10'($urandom), rows}, {10'($urandom), cols},
                 {10'($urandom), seam}, lim};
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= 2'(k);
            i_cfg_data  <= vals[k];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic stim_t mk_item(input logic [1:0] mode, input int row, input int col,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input bit chk,
                                      input logic [1:0] st);
        stim_t s;
        s.mode = mode;
        s.row  = 5'(row);
        s.col  = 5'(col);
        s.x    = x;
        s.y    = y;
        s.z    = z;
        s.chk  = chk;
        s.res  = '{18'sd0, 18'sd0, 18'sd0, st};
        return s;
    endfunction

    // mesh-like vertex: regular lattice, random bits, tiny spacing or flat
    function automatic stim_t mesh_vertex(input int shape, input int r, input int c,
                                          input int step);
        int jit;
        jit = step / 8 + 1;
        case (shape)
            0, 2: return mk_item(MODE_WRITE, r, c,
                                 c * step + $urandom_range(0, jit) - jit / 2,
                                 r * step + $urandom_range(0, jit) - jit / 2,
                                 $urandom_range(0, 2 * step) - step, 0, STAT_READ);
            1: return mk_item(MODE_WRITE, r, c, $urandom, $urandom, $urandom, 0, STAT_READ);
            default: return mk_item(MODE_WRITE, r, c, step, -step, 32'h0001_0000, 0,
                                    STAT_READ);
        endcase
    endfunction

    initial begin
        stim_t       dir_tab [$];
        stim_t       s;
        logic [5:0]  x_rows [7];
        logic [5:0]  x_cols [7];
        logic [5:0]  x_seam [7];
        logic [15:0] x_lim  [7];
        logic [5:0]  rows, cols, seam;
        logic [15:0] lim;
        int          nr, nc, shape, step, sent, phase, mix, r;

        x_rows = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd1, 6'd3, 6'd2};
        x_cols = '{6'd2, 6'd32, 6'd0, 6'd0, 6'd63, 6'd3, 6'd2};
        x_seam = '{6'd63, 6'd0, 6'd5, 6'd42, 6'd63, 6'd63, 6'd0};
        x_lim  = '{16'd0, 16'd65535, 16'd66, 16'd1000, 16'd65535, 16'd65535, 16'd0};

        mdl_rows        = RST_ROWS;
        mdl_cols        = RST_COLS;
        mdl_seam        = RST_SEAM;
        mdl_limit       = RST_LIMIT;
        for (int i = 0; i < NCELLS; i++)
            for (int k = 0; k < 3; k++) begin
                mdl_vtx[i][k] = 0;
                mdl_nrm[i][k] = 0;
                mdl_acc[i][k] = 0;
            end
        mismatches  = 0;
        fail_cnt    = 0;
        no_gaps     = 1'b0;
        hold_req    = 1'b0;
        cur_item    = mk_item(MODE_NOP, 0, 0, 0, 0, 0, 0, STAT_READ);
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = MODE_NOP;
        i_row       = '0;
        i_col       = '0;
        i_x         = '0;
        i_y         = '0;
        i_z         = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROWS;
        i_cfg_data  = '0;

        // empty reads, ignored items, unit square, degenerate corner, zero sum
        dir_tab.push_back(mk_item(MODE_READ, 0, 0, 0, 0, 0, 1, STAT_ZERO));
        dir_tab.push_back(mk_item(MODE_READ, 31, 31, 0, 0, 0, 1, STAT_ZERO));
        dir_tab.push_back(mk_item(MODE_NOP, 5, 5, '1, '1, '1, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_WRITE, 31, 31, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_READ, 31, 31, 0, 0, 0, 1, STAT_ZERO));
        dir_tab.push_back(mk_item(MODE_WRITE, 0, 0, 0, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_WRITE, 0, 1, 65536, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_WRITE, 1, 0, 0, 65536, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_WRITE, 1, 1, 65536, 65536, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 0, 1, STAT_DONE));
        dir_tab.push_back(mk_item(MODE_READ, 0, 0, 0, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_READ, 0, 1, 0, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_READ, 1, 0, 0, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_READ, 1, 1, 0, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_WRITE, 1, 1, 20, 65536, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 0, 1, STAT_DONE));
        dir_tab.push_back(mk_item(MODE_READ, 1, 0, 0, 0, 0, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_READ, 0, 1, 0, 0, 0, 0, STAT_READ));
        for (int k = 0; k < 4; k++)
            dir_tab.push_back(mk_item(MODE_WRITE, k / 2, k % 2, 7, 7, 7, 0, STAT_READ));
        dir_tab.push_back(mk_item(MODE_COMPUTE, 0, 0, 0, 0, 0, 1, STAT_DONE));
        dir_tab.push_back(mk_item(MODE_READ, 0, 0, 0, 0, 0, 1, STAT_ZERO));
        dir_tab.push_back(mk_item(MODE_READ, 1, 1, 0, 0, 0, 1, STAT_ZERO));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[n]) send_item(dir_tab[n]);

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            drain_results();
            if (phase < 7) begin
                rows = x_rows[phase];
                cols = x_cols[phase];
                seam = x_seam[phase];
                lim  = x_lim[phase];
            end else begin
                rows = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 1))
                                                   : 6'($urandom_range(2, 3));
                cols = 6'($urandom_range(2, 4));
                seam = 6'($urandom);
                r    = $urandom_range(0, 9);
                lim  = (r < 3) ? 16'($urandom) : (r < 6) ? 16'($urandom_range(0, 200))
                     : (r < 8) ? 16'd65535 : 16'd0;
            end
            program_grid(rows, cols, seam, lim);
            nr      = sat_rows(rows);
            nc      = sat_cols(cols);
            no_gaps = (phase % 5 == 3);
            r       = $urandom_range(0, 9);
            shape   = (phase == 5) ? 2 : (r < 5) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
            step    = (shape == 2) ? $urandom_range(0, 80) : $urandom_range(1, 1 << 20);

            // load the whole grid in use before the first compute
            for (int i = 0; i < nr; i++)
                for (int j = 0; j < nc; j++) begin
                    send_item(mesh_vertex(shape, i, j, step));
                    sent++;
                end
            send_item(mk_item(MODE_COMPUTE, $urandom, $urandom, $urandom, $urandom,
                              $urandom, 0, STAT_READ));
            sent++;

            if (phase == 9) begin
                // hold the result side off and keep pushing reads
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                for (int n = 0; n < 60; n++) begin
                    send_item(mk_item(MODE_READ, $urandom_range(0, nr - 1),
                                      $urandom_range(0, nc - 1), 0, 0, 0, 0, STAT_READ));
                    sent++;
                end
                no_gaps = 1'b0;
            end

            mix = $urandom_range(20, 50);
            for (int n = 0; n < mix; n++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    s = mk_item(MODE_READ, $urandom_range(0, nr - 1),
                                $urandom_range(0, nc - 1), $urandom, $urandom, $urandom,
                                0, STAT_READ);
                end else if (r < 65) begin
                    s = mk_item(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                                $urandom, 0, STAT_READ);
                end else if (r < 80) begin
                    s = mesh_vertex(shape, $urandom_range(0, nr - 1),
                                    $urandom_range(0, nc - 1), step);
                end else if (r < 91) begin
                    s = mesh_vertex(1, $urandom, $urandom, step);
                end else if (r < 96) begin
                    s = mk_item(MODE_NOP, $urandom, $urandom, $urandom, $urandom,
                                $urandom, 0, STAT_READ);
                end else if (nr * nc <= 16) begin
                    s = mk_item(MODE_COMPUTE, $urandom, $urandom, $urandom, $urandom,
                                $urandom, 0, STAT_READ);
                end else begin
                    s = mk_item(MODE_READ, 0, 0, 0, 0, 0, 0, STAT_READ);
                end
                send_item(s);
                if (s.mode != MODE_NOP) sent++;
            end
            phase++;
        end

        drain_results();
        fail_cnt += pending_normals.size();
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
